### design/sbde_pkg.sv
// Package for the signed BCD display encoder.
// Holds the segment patterns, the placement command codes and the
// controller/datapath interface structs. No dependencies.
package sbde_pkg;

  localparam int MagW    = 16;              // magnitude width, covers 32768
  localparam int Digits  = 5;               // BCD digits of the full conversion
  localparam int BcdW    = 4 * Digits;
  localparam int CntW    = $clog2(MagW);
  localparam int WordW   = 32;

  localparam logic [WordW-1:0] DASH_PATTERN = 32'h0200_0000;
  localparam logic [WordW-1:0] ZERO_PATTERN = 32'hfc00_0000;
  localparam logic [MagW-1:0]  CLAMP_LIMIT  = 16'd999;

  // Placement commands; code 3 behaves like CMD_HIGH.
  localparam logic [1:0] CMD_FULL = 2'd0;
  localparam logic [1:0] CMD_LOW  = 2'd1;
  localparam logic [1:0] CMD_HIGH = 2'd2;

  typedef struct packed {
    logic load;    // capture inputs and start a conversion
    logic shift;   // one double-dabble step
  } sbde_ctrl_t;

  typedef struct packed {
    logic last;    // current step is the final one
  } sbde_stat_t;

endpackage

### design/sbde_datapath.sv
// Datapath of the signed BCD display encoder: sign handling, clamp and
// a bit-serial double-dabble converter with output placement.
// Depends on sbde_pkg.
module sbde_datapath
  import sbde_pkg::*;
(
  input  logic                  clk,
  input  logic [1:0]            cmd,
  input  logic signed [MagW-1:0] value,
  input  sbde_ctrl_t            ctl,
  output sbde_stat_t            sts,
  output logic [WordW-1:0]      sign_pattern,
  output logic                  sign_to_low,
  output logic [WordW-1:0]      bcd_word
);

  logic [1:0]      cmd_q;
  logic            neg;
  logic [MagW-1:0] bin;
  logic [BcdW-1:0] bcd;
  logic [CntW-1:0] cnt;

  logic [MagW-1:0] mag;
  logic [MagW-1:0] mag_clamped;
  logic [BcdW-1:0] adj;

  // Magnitude of the two's complement input; -32768 maps to 0x8000.
  always_comb begin
    mag = value[MagW-1] ? (~value + 1'b1) : value;
    if (cmd != CMD_FULL && mag > CLAMP_LIMIT) begin
      mag_clamped = CLAMP_LIMIT;
    end else begin
      mag_clamped = mag;
    end
  end

  // Add-3 correction on every digit of 5 or more
  always_comb begin
    for (int k = 0; k < Digits; k++) begin
      if (bcd[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd[4*k +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
      neg   <= value[MagW-1];
      bin   <= mag_clamped;
      bcd   <= '0;
      cnt   <= '0;
    end else if (ctl.shift) begin
      bcd   <= {adj[BcdW-2:0], bin[MagW-1]};
      bin   <= {bin[MagW-2:0], 1'b0};
      cnt   <= cnt + 1'b1;
    end
  end

  assign sts.last = (cnt == CntW'(MagW - 1));

  assign sign_pattern = neg ? DASH_PATTERN : ZERO_PATTERN;
  assign sign_to_low  = (cmd_q == CMD_LOW);

  // Clamped values fit in three digits; upper digits are zero then.
  always_comb begin
    case (cmd_q)
      CMD_FULL: bcd_word = {{(WordW-BcdW){1'b0}}, bcd};
      CMD_LOW:  bcd_word = {20'd0, bcd[11:0]};
      default:  bcd_word = {4'd0, bcd[11:0], 16'd0};
    endcase
  end

endmodule

### design/sbde_ctrl.sv
// Controller of the signed BCD display encoder: one-hot state machine
// sequencing load, sixteen conversion steps and the result strobe.
// Depends on sbde_pkg.
module sbde_ctrl
  import sbde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  sbde_stat_t sts,
  output sbde_ctrl_t ctl,
  output logic       busy,
  output logic       done
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_CONV;
      S_CONV:  if (sts.last) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign ctl.load  = (state == S_IDLE) && start;
  assign ctl.shift = (state == S_CONV);

`ifndef SYNTHESIS
  // A strobe only follows the final conversion step
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.shift && sts.last))
    else $error("result strobe without finished conversion");

  // An accepted transaction keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not start conversion");

  // Strobe lasts one cycle and frees the block
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe held or block stuck busy");
`endif

endmodule

### design/signed_bcd_display_encoder.sv
// Top level of the signed BCD display encoder.
// Instantiates sbde_ctrl and sbde_datapath; depends on sbde_pkg.
//
//  channel   handshake          payload
//  --------  -----------------  -----------------------------------------
//  request   start / busy       cmd[1:0], value[15:0] (signed)
//  result    done (1-cycle)     sign_pattern[31:0], sign_to_low, bcd_word[31:0]
//
//  A transaction is accepted at an edge with start high and busy low.
//  Conversion is a bit-serial double dabble, one magnitude bit per cycle:
//  done rises after the final conversion step and lasts one cycle. No new
//  transaction is taken while busy; the next one can be taken in the cycle after
//  the strobe. The 16-bit magnitude width of the shift loop sets the step count.
//  Result ports are valid only while done is high; the receiver cannot stall.
//  rst (synchronous) returns the controller to idle; datapath has no reset.
module signed_bcd_display_encoder
  import sbde_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              cmd,
  input  logic signed [MagW-1:0]  value,
  output logic                    done,
  output logic [WordW-1:0]        sign_pattern,
  output logic                    sign_to_low,
  output logic [WordW-1:0]        bcd_word
);

  sbde_ctrl_t ctl;   // controller commands
  sbde_stat_t sts;   // datapath status

  // Sequencer: idle -> convert (16 steps) -> strobe result
  sbde_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  // Sign, clamp, converter and placement; result registers hold until next load
  sbde_datapath u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .value        (value),
    .ctl          (ctl),
    .sts          (sts),
    .sign_pattern (sign_pattern),
    .sign_to_low  (sign_to_low),
    .bcd_word     (bcd_word)
  );

endmodule

### tb/tb_signed_bcd_display_encoder.sv
// Self-checking testbench for signed_bcd_display_encoder.
// Drives random and directed conversion requests through start/busy and checks
// every done strobe against an in-bench model of the display words. Needs sbde_pkg.
`timescale 1ns / 1ps

module tb_signed_bcd_display_encoder;
  import sbde_pkg::*;

  // Expected display words for one transaction, plus the request that made them
  typedef struct {
    logic [1:0]        req_cmd;
    logic signed [15:0] req_value;
    logic [WordW-1:0]  sign_pattern;
    logic              sign_to_low;
    logic [WordW-1:0]  bcd_word;
  } display_words_t;

  // Holds the display words still owed by the block and compares each done strobe
  class display_scoreboard;
    display_words_t owed_q[$];
    int errors;
    int checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // Sign digit, register select and packed BCD for one request
    function display_words_t encode_display(logic [1:0] c, logic signed [15:0] v);
      display_words_t w;
      logic [16:0]    mag;
      int unsigned    m;
      int unsigned    n_digits;
      int unsigned    first_nib;
      int             k;
      w.req_cmd   = c;
      w.req_value = v;
      // 17-bit magnitude so -32768 maps to 32768 instead of folding to zero
      mag = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
      w.sign_pattern = v[15] ? DASH_PATTERN : ZERO_PATTERN;
      if (c == CMD_FULL) begin
        n_digits      = 5;
        first_nib     = 0;
        w.sign_to_low = 1'b0;
      end else begin
        if (mag > {1'b0, CLAMP_LIMIT}) mag = {1'b0, CLAMP_LIMIT};
        n_digits = 3;
        if (c == CMD_LOW) begin
          first_nib     = 0;
          w.sign_to_low = 1'b1;
        end else begin
          // code 3 falls through to the high-half placement
          first_nib     = 4;
          w.sign_to_low = 1'b0;
        end
      end
      w.bcd_word = '0;
      m = mag;
      for (k = 0; k < n_digits; k++) begin
        w.bcd_word[4*(first_nib+k) +: 4] = 4'(m % 10);
        m = m / 10;
      end
      return w;
    endfunction

    function void note_request(logic [1:0] c, logic signed [15:0] v);
      owed_q.push_back(encode_display(c, v));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void check_result(logic [WordW-1:0] pat, logic to_low, logic [WordW-1:0] bcd);
      display_words_t e;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected done, pattern=%h to_low=%b bcd=%h", $time, pat, to_low, bcd);
        return;
      end
      e = owed_q.pop_front();
      checked++;
      if (pat !== e.sign_pattern) begin
        errors++;
        $display("%0t: cmd=%0d value=%0d sign_pattern expected %h actual %h",
                 $time, e.req_cmd, e.req_value, e.sign_pattern, pat);
      end
      if (to_low !== e.sign_to_low) begin
        errors++;
        $display("%0t: cmd=%0d value=%0d sign_to_low expected %b actual %b",
                 $time, e.req_cmd, e.req_value, e.sign_to_low, to_low);
      end
      if (bcd !== e.bcd_word) begin
        errors++;
        $display("%0t: cmd=%0d value=%0d bcd_word expected %h actual %h",
                 $time, e.req_cmd, e.req_value, e.bcd_word, bcd);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd = CMD_FULL;
  logic signed [15:0] value = '0;
  logic               done;
  logic [WordW-1:0]   sign_pattern;
  logic               sign_to_low;
  logic [WordW-1:0]   bcd_word;

  display_scoreboard sb = new();
  int                cmd_count [4];
  int                sent;

  signed_bcd_display_encoder DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .value        (value),
    .done         (done),
    .sign_pattern (sign_pattern),
    .sign_to_low  (sign_to_low),
    .bcd_word     (bcd_word)
  );

  always #1 clk = ~clk;

  // Results cannot be held off: every done strobe is checked at the edge that ends it
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(sign_pattern, sign_to_low, bcd_word);
  end

  // Hard stop well past the slowest legal run
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

  // Called at a falling edge. Idles the request side during the gap, then presents
  // one transaction and holds it until busy is low. busy only moves at rising edges,
  // so a low busy seen here means the next rising edge accepts the transaction; the
  // expectation is queued now, ahead of any possible done. Returns at the falling
  // edge after acceptance with start still high, so back-to-back requests never
  // lower and raise start within one time step.
  task automatic send_request(input logic [1:0] c, input logic signed [15:0] v,
                              input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    value <= v;
    while (busy) @(negedge clk);
    sb.note_request(c, v);
    cmd_count[c]++;
    sent++;
    @(negedge clk);
  endtask

  // Mostly back-to-back or short idles, with an occasional long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Weighted toward the clamp boundary, small magnitudes and the 16-bit extremes
  function automatic logic signed [15:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'($urandom);
    if (r < 7) return 16'(int'($urandom_range(0, 2200)) - 1100);
    if (r < 8) return 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(990, 1010)));
    if (r < 9) return 16'(int'($urandom_range(0, 1)) ? 16'sh8000 + 16'($urandom_range(0, 20))
                                                      : 16'sh7fff - 16'($urandom_range(0, 20)));
    return 16'($urandom_range(0, 99999) % 65536);
  endfunction

  // Lowers start, waits a falling edge, then waits until every owed result is checked
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Directed corners: zero, unit steps, clamp edges, both extremes, all four codes
  logic [1:0]         dir_cmd [24] = '{
    CMD_FULL, CMD_LOW, CMD_HIGH, 2'd3,
    CMD_FULL, CMD_FULL, CMD_FULL, CMD_FULL,
    CMD_LOW, CMD_HIGH, CMD_LOW, CMD_HIGH,
    CMD_LOW, CMD_HIGH, CMD_LOW, CMD_HIGH,
    CMD_FULL, CMD_FULL, 2'd3, 2'd3,
    CMD_LOW, CMD_HIGH, CMD_FULL, CMD_LOW
  };
  logic signed [15:0] dir_value [24] = '{
    16'sd0, 16'sd0, 16'sd0, 16'sd0,
    16'sd32767, -16'sd32768, -16'sd1, 16'sd1,
    16'sd999, 16'sd999, 16'sd1000, -16'sd1000,
    -16'sd999, 16'sd998, -16'sd32768, 16'sd32767,
    16'sd12345, -16'sd9876, 16'sd10, -16'sd1001,
    16'sd9, -16'sd100, 16'sd99, 16'sd100
  };

  initial begin
    int i;
    int gap;
    for (i = 0; i < 4; i++) cmd_count[i] = 0;
    sent = 0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < 24; i++) send_request(dir_cmd[i], dir_value[i], (i % 3 == 2) ? 1 : 0);

    // Let the directed set finish completely before random traffic
    drain_results();

    for (i = 0; i < 850; i++) begin
      gap = pick_gap();
      // Unbroken back-to-back stretch
      if (i >= 300 && i < 400) gap = 0;
      // Hold off new requests until the block has delivered everything owed
      if (i == 500 || i == 700) drain_results();
      send_request(2'($urandom_range(0, 3)), pick_value(), gap);
    end

    drain_results();
    // Catch any stray done after the last expected one
    repeat (40) @(negedge clk);

    $display("Sent %0d transactions: full=%0d low=%0d high=%0d code3=%0d; %0d results checked",
             sent, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### signed_bcd_display_encoder.f
design/sbde_pkg.sv
design/sbde_datapath.sv
design/sbde_ctrl.sv
design/signed_bcd_display_encoder.sv
tb/tb_signed_bcd_display_encoder.sv
